// ===== src/htnd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htnd_pkg
// Shared constants, types and digit/byte helpers for the hex token decoder.
// ----------------------------------------------------------------------------
package htnd_pkg;

  localparam int unsigned ACC_W   = 64;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CNT_W-1:0] CNT_SAT    = CNT_W'(17);
  localparam logic [CNT_W-1:0] DOUBLE_LEN = CNT_W'(16);

  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [7:0] CH_UG    = 8'h47;  // 'G'
  localparam logic [7:0] CH_UV    = 8'h56;  // 'V'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
  localparam logic [7:0] CH_LG    = 8'h67;  // 'g'
  localparam logic [7:0] CH_LV    = 8'h76;  // 'v'
  localparam logic [7:0] HEX_A    = 8'h0A;

  localparam logic [2:0] REG_SWAP_ORDER = 3'h0;

  localparam logic KIND_INT  = 1'b0;
  localparam logic KIND_REAL = 1'b1;

  // decoded input item
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               kind;
    logic               last;
    logic               is_minus;
    logic               is_g;
  } char_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c, input logic kind);
    logic [DIGIT_W-1:0] d;
    d = '0;
    if (kind == KIND_REAL) begin
      if (c inside {[CH_UG:CH_UV]}) d = DIGIT_W'(c - CH_UG);
      else if (c inside {[CH_LG:CH_LV]}) d = DIGIT_W'(c - CH_LG);
    end else begin
      if (c inside {[CH_0:CH_9]}) d = DIGIT_W'(c - CH_0);
      else if (c inside {[CH_UA:CH_UF]}) d = DIGIT_W'(c - CH_UA + HEX_A);
      else if (c inside {[CH_LA:CH_LF]}) d = DIGIT_W'(c - CH_LA + HEX_A);
    end
    return d;
  endfunction

  function automatic logic [63:0] rev8(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = v[8*(7-i) +: 8];
    return r;
  endfunction

  function automatic logic [31:0] rev4(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) r[8*i +: 8] = v[8*(3-i) +: 8];
    return r;
  endfunction

endpackage

// ===== src/hex_token_number_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_token_number_decoder_core
// Decodes number tokens, one character per item, into 64-bit patterns.
// ----------------------------------------------------------------------------
// Usage:
//   Character items enter on char_valid/char_stall with char_code, kind and
//   last. Each character is decoded to a digit in the input register, shifted
//   into the 64-bit accumulator in the next stage, and on a last character
//   the result (integer, double or float pattern) is formed into the output
//   register and offered on res_valid/res_stall.
//   A result moves from the input register through the accumulator to the
//   output register. Throughput: one character per cycle; the three stages
//   advance together whenever the output register is empty or being taken.
//   When the receiver stalls with a result waiting, char_stall goes high and
//   the whole pipe holds; characters that produce no result still move only
//   with the pipe.
//   swap_order (APB register 0, byte address 0) byte-reverses real results;
//   write it only while the block is idle. prdata returns it.
//   Reset (rst, synchronous) empties the pipe, clears the accumulator and
//   token state, and sets swap_order to 0.
// ----------------------------------------------------------------------------
module hex_token_number_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  input  logic        kind,
  input  logic        last,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [63:0] result_value,
  output logic        is_single,
  output logic        status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import htnd_pkg::*;

  logic              advance;
  logic              swap_order;
  logic              v1;
  char_t             ch;
  logic              v2;
  logic              kind2;
  logic              last2;
  logic              tok_done;
  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  logic              fminus;
  logic              fg;
  logic [ACC_W-1:0]  acc_base;
  logic [CNT_W-1:0]  cnt_base;
  logic [CNT_W-1:0]  cnt_next;
  logic [ACC_W-1:0]  res_next;
  logic              single_next;
  logic              status_next;

  assign advance    = !(res_valid && res_stall);
  assign char_stall = !advance;
  assign pready     = 1'b1;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_order <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == REG_SWAP_ORDER) begin
      swap_order <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_SWAP_ORDER) prdata[0] = swap_order;
  end

  // stage 1: decode
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && char_valid) begin
      ch.digit    <= digit_of(char_code, kind);
      ch.kind     <= kind;
      ch.last     <= last;
      ch.is_minus <= (char_code == CH_MINUS);
      ch.is_g     <= (char_code == CH_UG) || (char_code == CH_LG);
    end
  end

  // stage 2: accumulate; a finished token restarts from zero
  assign acc_base = tok_done ? '0 : acc;
  assign cnt_base = tok_done ? '0 : cnt;
  assign cnt_next = (cnt_base < CNT_SAT) ? cnt_base + CNT_W'(1) : cnt_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2       <= 1'b0;
      tok_done <= 1'b0;
      acc      <= '0;
      cnt      <= '0;
      fminus   <= 1'b0;
      fg       <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
      if (v1) begin
        acc      <= {acc_base[ACC_W-DIGIT_W-1:0], ch.digit};
        cnt      <= cnt_next;
        tok_done <= ch.last;
        if (cnt_base == '0) begin
          fminus <= ch.is_minus;
          fg     <= ch.is_g;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v1) begin
      kind2 <= ch.kind;
      last2 <= ch.last;
    end
  end

  // stage 3: result
  always_comb begin
    res_next    = acc;
    single_next = 1'b0;
    status_next = 1'b0;
    if (kind2 == KIND_INT) begin
      if (fminus) begin
        if (acc[ACC_W-1] && |acc[ACC_W-2:0]) status_next = 1'b1;
        else res_next = '0 - acc;
      end
    end else if (cnt == CNT_W'(1) && fg) begin
      res_next = '0;
    end else if (cnt == DOUBLE_LEN || fg) begin
      res_next = swap_order ? rev8(acc) : acc;
    end else begin
      res_next    = {32'b0, swap_order ? rev4(acc[31:0]) : acc[31:0]};
      single_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= v2 && last2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v2 && last2) begin
      result_value <= res_next;
      is_single    <= single_next;
      status       <= status_next;
    end
  end

  // checks
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && v2 && last2) |=> res_valid)
    else $error("last item did not produce a result");

  a_no_result_without_last: assert property (@(posedge clk) disable iff (rst)
    (advance && !(v2 && last2)) |=> !res_valid)
    else $error("result without a last item");

  a_cnt_saturates: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_SAT)
    else $error("char count beyond saturation");

  a_single_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(is_single && status))
    else $error("float result with overflow status");

  a_single_high_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && is_single) |-> (result_value[63:32] == 32'b0))
    else $error("float result with nonzero high word");

endmodule
